// ===== design/i2cbm_pkg.sv =====
// Package: shared types and constants for the I2C byte master.
`default_nettype none
package i2cbm_pkg;

  // Command codes carried in req_type
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_UNIT_DELAY = 2'd0;
  localparam cfg_idx_t CFG_START_HOLD = 2'd1;
  localparam cfg_idx_t CFG_STRETCH    = 2'd2;

  localparam logic [7:0] UNIT_DELAY_RST = 8'd3;
  localparam logic [7:0] START_HOLD_RST = 8'd3;
  localparam logic [7:0] STRETCH_RST    = 8'd40;

  typedef struct packed {
    logic [7:0] unit_delay_ticks;
    logic [7:0] start_hold_ticks;
    logic [7:0] stretch_limit;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] req_type;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       scl_level;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       stretch_gave_up;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/i2cbm_if.sv =====
// Interfaces: valid/ready channels for input ticks and result items.
`default_nettype none
interface i2cbm_in_if;
  logic                 valid;
  logic                 ready;
  i2cbm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cbm_out_if;
  logic                 valid;
  logic                 ready;
  i2cbm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/i2cbm_seq.sv =====
// Sequencer: bus phase state machine, advanced once per accepted tick.
`default_nettype none
module i2cbm_seq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step_en,
  input  i2cbm_pkg::in_item_t   item,
  input  i2cbm_pkg::cfg_t       cfg,
  output i2cbm_pkg::out_item_t  result
);
  import i2cbm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_WAIT    = 4'd1,
    PH_D1      = 4'd2,
    PH_D2      = 4'd3,
    PH_D3      = 4'd4,
    PH_D4      = 4'd5,
    PH_SETUP   = 4'd6,
    PH_HIGH    = 4'd7,
    PH_LOWTAIL = 4'd8
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [1:0] active_r, active_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic       nack_r, nack_nxt;
  logic [7:0] rcv_r, rcv_nxt;
  logic       ack_r, ack_nxt;
  logic       tmo_r, tmo_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;

  logic [7:0] unit_len, hold_len, tick_inc, wait_inc;
  logic [3:0] bit_inc;
  logic       hit_u, hit_h, done;

  // zero delay acts as one tick
  assign unit_len = (cfg.unit_delay_ticks == 8'd0) ? 8'd1 : cfg.unit_delay_ticks;
  assign hold_len = (cfg.start_hold_ticks == 8'd0) ? 8'd1 : cfg.start_hold_ticks;
  assign tick_inc = tick_r + 8'd1;
  assign wait_inc = wait_r + 8'd1;
  assign bit_inc  = bit_r + 4'd1;
  assign hit_u    = (tick_inc >= unit_len);
  assign hit_h    = (tick_inc >= hold_len);

  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    tick_nxt   = tick_r;
    wait_nxt   = wait_r;
    nack_nxt   = nack_r;
    rcv_nxt    = rcv_r;
    ack_nxt    = ack_r;
    tmo_nxt    = tmo_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    done       = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        if (item.cmd_valid) begin
          active_nxt = item.req_type;
          bit_nxt    = 4'd0;
          tick_nxt   = 8'd0;
          wait_nxt   = 8'd0;
          case (item.req_type)
            CMD_START: begin
              sda_nxt   = 1'b0;
              scl_nxt   = 1'b0;
              phase_nxt = PH_WAIT;
            end
            CMD_STOP: phase_nxt = PH_D1;
            CMD_WRITE: begin
              sda_nxt   = ~item.tx_byte[7];
              shift_nxt = {item.tx_byte[6:0], 1'b0};
              phase_nxt = PH_SETUP;
            end
            default: begin
              nack_nxt  = item.send_nack;
              shift_nxt = 8'd0;
              sda_nxt   = 1'b0;
              scl_nxt   = 1'b0;
              phase_nxt = PH_WAIT;
            end
          endcase
        end
      end
      PH_WAIT: begin
        if (item.scl_level || (wait_r >= cfg.stretch_limit)) begin
          tmo_nxt  = ~item.scl_level;
          tick_nxt = 8'd0;
          wait_nxt = 8'd0;
          if (active_r == CMD_START)     phase_nxt = PH_D1;
          else if (active_r == CMD_STOP) phase_nxt = PH_D3;
          else                           phase_nxt = PH_HIGH;
        end else if (hit_u) begin
          tick_nxt = 8'd0;
          wait_nxt = wait_inc;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_D1: begin
        tick_nxt = hit_u ? 8'd0 : tick_inc;
        if (hit_u) begin
          sda_nxt   = 1'b1;
          wait_nxt  = 8'd0;
          phase_nxt = PH_D2;
        end
      end
      PH_D2: begin
        if ((active_r == CMD_START) ? hit_h : hit_u) begin
          tick_nxt = 8'd0;
          wait_nxt = 8'd0;
          if (active_r == CMD_START) begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_D3;
          end else begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_WAIT;
          end
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_D3: begin
        tick_nxt = hit_u ? 8'd0 : tick_inc;
        if (hit_u) begin
          if (active_r == CMD_START) begin
            done = 1'b1;
          end else begin
            sda_nxt   = 1'b0;
            wait_nxt  = 8'd0;
            phase_nxt = PH_D4;
          end
        end
      end
      PH_D4: begin
        tick_nxt = hit_u ? 8'd0 : tick_inc;
        done     = hit_u;
      end
      PH_SETUP: begin
        tick_nxt = hit_u ? 8'd0 : tick_inc;
        if (hit_u) begin
          scl_nxt   = 1'b0;
          wait_nxt  = 8'd0;
          phase_nxt = PH_WAIT;
        end
      end
      PH_HIGH: begin
        tick_nxt = hit_u ? 8'd0 : tick_inc;
        if (hit_u) begin
          wait_nxt = wait_inc;
          if (wait_inc >= 8'd2) begin
            // sample SDA on the last high tick
            if ((active_r == CMD_READ) && (bit_r < 4'd8))
              shift_nxt = {shift_r[6:0], item.sda_level};
            if ((active_r == CMD_WRITE) && (bit_r >= 4'd8))
              ack_nxt = ~item.sda_level;
            scl_nxt   = 1'b1;
            wait_nxt  = 8'd0;
            phase_nxt = PH_LOWTAIL;
          end
        end
      end
      PH_LOWTAIL: begin
        tick_nxt = hit_u ? 8'd0 : tick_inc;
        if (hit_u) begin
          bit_nxt  = bit_inc;
          wait_nxt = 8'd0;
          if (bit_inc >= 4'd9) begin
            if (active_r == CMD_READ) rcv_nxt = shift_r;
            done = 1'b1;
          end else if (bit_inc == 4'd8) begin
            // acknowledge slot: release for write, drive ACK/NACK for read
            sda_nxt   = (active_r == CMD_WRITE) ? 1'b0 : ~nack_r;
            scl_nxt   = 1'b0;
            phase_nxt = PH_WAIT;
          end else if (active_r == CMD_WRITE) begin
            sda_nxt   = ~shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = PH_SETUP;
          end else begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_WAIT;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = 8'd0;
        wait_nxt  = 8'd0;
      end
    endcase

    if (done) begin
      phase_nxt = PH_IDLE;
      tick_nxt  = 8'd0;
      wait_nxt  = 8'd0;
    end
  end

  always_comb begin
    result.scl_pull_low    = scl_nxt;
    result.sda_pull_low    = sda_nxt;
    result.busy_res        = (phase_nxt != PH_IDLE);
    result.done_res        = done;
    result.rx_byte         = rcv_nxt;
    result.ack_seen        = ack_nxt;
    result.stretch_gave_up = tmo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      active_r <= 2'd0;
      bit_r    <= 4'd0;
      shift_r  <= 8'd0;
      tick_r   <= 8'd0;
      wait_r   <= 8'd0;
      nack_r   <= 1'b0;
      rcv_r    <= 8'd0;
      ack_r    <= 1'b0;
      tmo_r    <= 1'b0;
      scl_r    <= 1'b0;
      sda_r    <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      tick_r   <= tick_nxt;
      wait_r   <= wait_nxt;
      nack_r   <= nack_nxt;
      rcv_r    <= rcv_nxt;
      ack_r    <= ack_nxt;
      tmo_r    <= tmo_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/i2c_byte_master_top.sv =====
// Top level: I2C byte master with tick channel, result channel and config port.
//
//  channel   dir   handshake         payload
//  in_ch     in    valid/ready       cmd_valid req_type tx_byte send_nack scl sda
//  out_ch    out   valid/ready       scl/sda pull, busy, done, rx_byte, ack, gave_up
//  cfg_*     in    cfg_we (no wait)  cfg_idx, cfg_data
//
// One tick per clock cycle while out_ch is not stalled: the sequencer advances on each
// accepted tick and the result lands in the output register on the next edge.
// A new tick is taken whenever the output register is empty or being drained.
// Stalls on out_ch backpressure in_ch; nothing is lost or repeated.
// Synchronous active-low reset clears the sequencer and loads register defaults.
`default_nettype none
module i2c_byte_master_top (
  input  wire                  clk,
  input  wire                  rst_n,
  i2cbm_in_if.sink             in_ch,
  i2cbm_out_if.source          out_ch,
  input  wire                  cfg_we,
  input  i2cbm_pkg::cfg_idx_t  cfg_idx,
  input  wire [7:0]            cfg_data
);
  import i2cbm_pkg::*;

  cfg_t      cfg_r;
  out_item_t out_data_r;
  out_item_t step_res;
  logic      out_valid_r, out_valid_nxt;
  logic      in_acc;

  // accept while the result slot is free or emptying this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign out_valid_nxt = in_acc ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  i2cbm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_acc),
    .item    (in_ch.data),
    .cfg     (cfg_r),
    .result  (step_res)
  );

  // configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_delay_ticks <= UNIT_DELAY_RST;
      cfg_r.start_hold_ticks <= START_HOLD_RST;
      cfg_r.stretch_limit    <= STRETCH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_UNIT_DELAY: cfg_r.unit_delay_ticks <= cfg_data;
        CFG_START_HOLD: cfg_r.start_hold_ticks <= cfg_data;
        CFG_STRETCH:    cfg_r.stretch_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= step_res;
    end
  end

endmodule
`default_nettype wire

// ===== design/i2cbm_checker.sv =====
// Checker: port-level assertions for the I2C byte master, bound to the top.
`default_nettype none
module i2cbm_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input i2cbm_pkg::out_item_t  out_data
);

  // stalled result holds (protocol)
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an empty result slot never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result slot");

  // every accepted tick yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick gave no result");

  // a finishing command leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while busy");

  // reset empties the result slot
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind i2c_byte_master_top i2cbm_checker u_i2cbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire
